// ===== sv/pavs_pkg.sv =====
// Shared constants for the additive voice synthesizer.
// Unit widths, command and register codes, pitch and harmonic tables.
// No dependencies.
package pavs_pkg;

	localparam int MUL_W     = 26;
	localparam int DIV_NUM_W = 40;
	localparam int DIV_DEN_W = 24;
	localparam int DIV_QUO_W = 18;
	localparam int DIV_CNT_W = 5;

	typedef enum logic [1:0] {
		CMD_NOTE = 2'd0,
		CMD_TICK = 2'd1,
		CMD_SEEK = 2'd2
	} cmd_t;

	localparam logic [1:0] REG_GAIN    = 2'd0;
	localparam logic [1:0] REG_ATTACK  = 2'd1;
	localparam logic [1:0] REG_RELEASE = 2'd2;

	localparam logic [31:0] SEMI_Q30 [12] = '{
		32'd1073741824, 32'd1137589836, 32'd1205234447, 32'd1276901421,
		32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
		32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
	};

	localparam logic [14:0] HARM_W [4] = '{15'd18022, 15'd8110, 15'd3965, 15'd1802};

endpackage

// ===== sv/pavs_ram.sv =====
// Generic single-port RAM with registered read data.
// Used for the voice slot rows. No dependencies.
module pavs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/pavs_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on pavs_pkg for the operand width.
module pavs_mul (
	input  logic                                clk,
	input  logic signed [pavs_pkg::MUL_W-1:0]   a,
	input  logic signed [pavs_pkg::MUL_W-1:0]   b,
	output logic signed [2*pavs_pkg::MUL_W-1:0] p
);

	logic signed [2*pavs_pkg::MUL_W-1:0] p_s1;

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

	assign p = p_s1;

endmodule

// ===== sv/pavs_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// The quotient must fit DIV_QUO_W bits. Depends on pavs_pkg.
module pavs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pavs_pkg::DIV_NUM_W-1:0]    num,
	input  logic [pavs_pkg::DIV_DEN_W-1:0]    den,
	output logic                              done,
	output logic [pavs_pkg::DIV_QUO_W-1:0]    quo
);

	localparam int NW = pavs_pkg::DIV_NUM_W;
	localparam int DW = pavs_pkg::DIV_DEN_W;
	localparam int QW = pavs_pkg::DIV_QUO_W;
	localparam int CW = pavs_pkg::DIV_CNT_W;

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] sh_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fit;

	assign trial = {rem_q, sh_q[QW-1]};
	assign fit   = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(num[NW-1:QW]);
			sh_q  <= num[QW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			sh_q  <= {sh_q[QW-2:0], fit};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

endmodule

// ===== sv/polyphonic_additive_voice_synth.sv =====
// Top level of the additive voice synthesizer: sequencer, slot state, config.
// Uses pavs_pkg, pavs_ram (slot rows), pavs_mul and pavs_div (shared units).
//
// Usage:
//   s_* channel takes command words: tuser is the command (note, tick, seek),
//   tdata carries note, velocity, start frame and release frame.
//   m_* channel gives one word per tick: limited sample and live voice count.
//   cfg_* channel writes gain, attack length and release length; the user must
//   write them only while idle, and the block itself leaves this unchecked.
// Sequence:
//   Seek and unknown commands are handled in the idle state. A note reads the
//   slots in turn up to the first free one, or all of them when all are full.
//   A tick visits every slot in turn, skipping free slots and ones not yet
//   started, with an attack divide and a release divide and scale where a
//   sounding slot needs them; the limiter and output step follow, and the
//   limiter divide is skipped when the mix clips. Input is held off while busy.
// Reset:
//   All voices free, frame counter zero, registers at their defaults.
// Stall:
//   A finished word waits in the output register; the next command is taken
//   meanwhile, and a following tick holds in its last step until it drains.
module polyphonic_additive_voice_synth #(
	parameter int VOICES      = 24,
	parameter int SAMPLE_RATE = 48000,
	parameter int PHASE_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // midi_note, velocity, start_frame, release_frame
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // sample_out, voices_active
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int MW    = pavs_pkg::MUL_W;
	localparam int PB    = PHASE_BITS;
	localparam int VW    = VOICES > 1 ? $clog2(VOICES) : 1;
	localparam int CW    = $clog2(VOICES + 1);
	localparam int MIX_W = 18 + $clog2(VOICES + 1);
	localparam int XW    = MIX_W + 4;
	localparam int LVL_LO = PB;
	localparam int ON_LO  = PB + 15;
	localparam int REL_LO = PB + 47;
	localparam int PH_LO  = PB + 79;
	localparam int ROW_W  = 2 * PB + 79;

	typedef enum logic [27:0] {
		ST_IDLE = 28'd1 << 0,
		ST_NRD  = 28'd1 << 1,
		ST_NCMP = 28'd1 << 2,
		ST_NWR  = 28'd1 << 3,
		ST_TRD  = 28'd1 << 4,
		ST_TCHK = 28'd1 << 5,
		ST_ADIV = 28'd1 << 6,
		ST_REL  = 28'd1 << 7,
		ST_RDIV = 28'd1 << 8,
		ST_RMUL = 28'd1 << 9,
		ST_RCHK = 28'd1 << 10,
		ST_PH   = 28'd1 << 11,
		ST_HSQ  = 28'd1 << 12,
		ST_HC1  = 28'd1 << 13,
		ST_HC2  = 28'd1 << 14,
		ST_HC3  = 28'd1 << 15,
		ST_HC4  = 28'd1 << 16,
		ST_HC5  = 28'd1 << 17,
		ST_VT1  = 28'd1 << 18,
		ST_VT2  = 28'd1 << 19,
		ST_VT3  = 28'd1 << 20,
		ST_NEXT = 28'd1 << 21,
		ST_FG   = 28'd1 << 22,
		ST_FL0  = 28'd1 << 23,
		ST_FL1  = 28'd1 << 24,
		ST_FL2  = 28'd1 << 25,
		ST_FL3  = 28'd1 << 26,
		ST_OUT  = 28'd1 << 27
	} state_t;

	logic [PB-1:0] step_tab [128];
	logic [14:0]   lvl_tab  [128];

	for (genvar n = 0; n < 128; n++) begin : g_tab
		localparam int D  = n + 3;
		localparam int O  = D / 12 - 6;
		localparam int E  = PHASE_BITS + O - 30;
		localparam int EP = (E >= 0) ? E : 0;
		localparam int EN = (E < 0) ? -E : 0;
		localparam logic [63:0] NUM = 64'd440 * {32'd0, pavs_pkg::SEMI_Q30[D % 12]};
		localparam logic [63:0] DEN = 64'(SAMPLE_RATE) << EN;
		localparam logic [63:0] STEP = (E >= 0) ?
			(((NUM << EP) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE)) :
			((NUM + DEN / 2) / DEN);
		localparam int LV = (n * 16384 + 63) / 127;
		assign step_tab[n] = STEP[PB-1:0];
		assign lvl_tab[n]  = 15'((LV < 819) ? 819 : LV);
	end

	state_t                 state_q;
	logic [VW-1:0]          vidx_q;
	logic [VW-1:0]          best_q;
	logic [31:0]            best_on_q;
	logic [VOICES-1:0]      valid_q;
	logic [CW-1:0]          cnt_q;
	logic [31:0]            frame_q;
	logic [15:0]            gain_q;
	logic [15:0]            att_q;
	logic [15:0]            rel_q;
	logic [6:0]             note_q;
	logic [6:0]             vel_q;
	logic [31:0]            on_in_q;
	logic [31:0]            rl_in_q;
	logic [15:0]            env_q;
	logic [31:0]            base_q;
	logic [31:0]            ang_q;
	logic [1:0]             h_q;
	logic [16:0]            m_q;
	logic [18:0]            m2_q;
	logic signed [32:0]     acc_q;
	logic signed [MIX_W-1:0] mix_q;
	logic                   neg_q;
	logic [15:0]            res_q;
	logic                   m_tvalid_q;
	logic [23:0]            m_tdata_q;

	logic                   ram_we;
	logic [ROW_W-1:0]       ram_wdata;
	logic [ROW_W-1:0]       ram_rdata;
	logic [PB-1:0]          rd_step;
	logic [14:0]            rd_lvl;
	logic [31:0]            rd_on;
	logic [31:0]            rd_rel;
	logic [PB-1:0]          rd_ph;
	logic [PB-1:0]          new_ph;
	logic [31:0]            age;
	logic [31:0]            since;

	logic signed [MW-1:0]   mul_a;
	logic signed [MW-1:0]   mul_b;
	logic signed [2*MW-1:0] prod;
	logic signed [2*MW-1:0] p_sh15;
	logic signed [2*MW-1:0] p_sh12;

	logic                   div_start;
	logic [pavs_pkg::DIV_NUM_W-1:0] div_num;
	logic [pavs_pkg::DIV_DEN_W-1:0] div_den;
	logic                   div_done;
	logic [pavs_pkg::DIV_QUO_W-1:0] div_q;

	logic [16:0]            m_comb;
	logic [18:0]            m2c;
	logic [14:0]            inner;
	logic [15:0]            mid;
	logic signed [17:0]     sy;
	logic signed [17:0]     tone;
	logic signed [17:0]     p15s;
	logic signed [XW-1:0]   x;
	logic [XW-1:0]          mag;
	logic [14:0]            ysat;
	logic                   s_acc;
	logic                   last_v;

	assign rd_step = ram_rdata[PB-1:0];
	assign rd_lvl  = ram_rdata[LVL_LO +: 15];
	assign rd_on   = ram_rdata[ON_LO +: 32];
	assign rd_rel  = ram_rdata[REL_LO +: 32];
	assign rd_ph   = ram_rdata[PH_LO +: PB];
	assign new_ph  = rd_ph + rd_step;
	assign age     = frame_q - rd_on;
	assign since   = frame_q - rd_rel;

	assign p_sh15 = prod >>> 15;
	assign p_sh12 = prod >>> 12;
	assign m_comb = ang_q[30] ? 17'd32768 - {2'b00, ang_q[29:15]} : {2'b00, ang_q[29:15]};
	assign m2c    = p_sh15[18:0];
	assign inner  = 15'd21024 - {3'b000, p_sh15[11:0]};
	assign mid    = 16'd51472 - {1'b0, p_sh15[14:0]};
	assign sy     = ang_q[31] ? -$signed({1'b0, p_sh15[16:0]}) : $signed({1'b0, p_sh15[16:0]});
	assign tone   = 18'(acc_q >>> 15);
	assign p15s   = p_sh15[17:0];
	assign x      = p_sh12[XW-1:0];
	assign mag    = x[XW-1] ? XW'(-x) : XW'(x);
	assign ysat   = (div_q > 18'd32767) ? 15'd32767 : div_q[14:0];
	assign s_acc  = s_tvalid && s_tready;
	assign last_v = vidx_q == VW'(VOICES - 1);

	assign ram_wdata = (state_q == ST_NWR) ?
		{{PB{1'b0}}, rl_in_q, on_in_q, lvl_tab[vel_q], step_tab[note_q]} :
		{new_ph, rd_rel, rd_on, rd_lvl, rd_step};
	assign ram_we = (state_q == ST_NWR) || (state_q == ST_PH);

	pavs_ram #(
		.WIDTH(ROW_W),
		.DEPTH(VOICES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (vidx_q),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	pavs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	pavs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_q)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_RMUL: begin
				mul_a = MW'($signed({1'b0, env_q}));
				mul_b = MW'($signed({1'b0, div_q}));
			end
			ST_HSQ: begin
				mul_a = MW'($signed({1'b0, m_comb}));
				mul_b = MW'($signed({1'b0, m_comb}));
			end
			ST_HC1: begin
				mul_a = MW'($signed({1'b0, m2c}));
				mul_b = MW'(2320);
			end
			ST_HC2: begin
				mul_a = MW'($signed({1'b0, m2_q}));
				mul_b = MW'($signed({1'b0, inner}));
			end
			ST_HC3: begin
				mul_a = MW'($signed({1'b0, m_q}));
				mul_b = MW'($signed({1'b0, mid}));
			end
			ST_HC4: begin
				mul_a = MW'($signed({1'b0, pavs_pkg::HARM_W[h_q]}));
				mul_b = MW'(sy);
			end
			ST_VT1: begin
				mul_a = MW'(tone);
				mul_b = MW'($signed({1'b0, rd_lvl}));
			end
			ST_VT2: begin
				mul_a = MW'(p15s);
				mul_b = MW'($signed({1'b0, env_q}));
			end
			ST_FG: begin
				mul_a = MW'(mix_q);
				mul_b = MW'($signed({1'b0, gain_q}));
			end
			ST_FL0: begin
				mul_a = MW'($signed({1'b0, mag[16:0]}));
				mul_b = MW'($signed({1'b0, mag[16:0]}));
			end
			ST_FL1: begin
				mul_a = MW'($signed({1'b0, m_q}));
				mul_b = MW'($signed({1'b0, 22'd884736 + {3'b000, m2c}}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			ST_TCHK: begin
				div_start = (frame_q >= rd_on) && (age < {16'd0, att_q});
				div_num   = 40'({age[15:0], 15'd0});
				div_den   = 24'(att_q);
			end
			ST_REL: begin
				div_start = (frame_q >= rd_rel) && (since < {16'd0, rel_q});
				div_num   = 40'({rel_q - since[15:0], 15'd0});
				div_den   = 24'(rel_q);
			end
			ST_FL2: begin
				div_start = 1'b1;
				div_num   = prod[39:0];
				div_den   = 24'd884736 + 24'({m2_q, 3'b000}) + 24'(m2_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			cnt_q      <= '0;
			frame_q    <= '0;
			gain_q     <= 16'd4096;
			att_q      <= 16'd576;
			rel_q      <= 16'd4800;
			vidx_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					pavs_pkg::REG_GAIN:    gain_q <= cfg_data;
					pavs_pkg::REG_ATTACK:  att_q  <= cfg_data;
					pavs_pkg::REG_RELEASE: rel_q  <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						unique case (s_tuser)
							pavs_pkg::CMD_NOTE: begin
								vidx_q  <= '0;
								state_q <= ST_NRD;
							end
							pavs_pkg::CMD_TICK: begin
								vidx_q  <= '0;
								state_q <= ST_TRD;
							end
							pavs_pkg::CMD_SEEK: begin
								valid_q <= '0;
								cnt_q   <= '0;
								frame_q <= s_tdata[45:14];
							end
							default: ;
						endcase
					end
				end
				ST_NRD: begin
					state_q <= valid_q[vidx_q] ? ST_NCMP : ST_NWR;
				end
				ST_NCMP: begin
					if (last_v) begin
						vidx_q  <= (vidx_q == '0 || rd_on < best_on_q) ? vidx_q : best_q;
						state_q <= ST_NWR;
					end else begin
						vidx_q  <= vidx_q + 1'b1;
						state_q <= ST_NRD;
					end
				end
				ST_NWR: begin
					if (!valid_q[vidx_q]) begin
						cnt_q <= cnt_q + 1'b1;
					end
					valid_q[vidx_q] <= 1'b1;
					state_q         <= ST_IDLE;
				end
				ST_TRD: begin
					state_q <= valid_q[vidx_q] ? ST_TCHK : ST_NEXT;
				end
				ST_TCHK: begin
					if (frame_q < rd_on) begin
						state_q <= ST_NEXT;
					end else if (age < {16'd0, att_q}) begin
						state_q <= ST_ADIV;
					end else begin
						state_q <= ST_REL;
					end
				end
				ST_ADIV: begin
					if (div_done) begin
						state_q <= ST_REL;
					end
				end
				ST_REL: begin
					if (frame_q >= rd_rel) begin
						if (since < {16'd0, rel_q}) begin
							state_q <= ST_RDIV;
						end else begin
							valid_q[vidx_q] <= 1'b0;
							cnt_q           <= cnt_q - 1'b1;
							state_q         <= ST_NEXT;
						end
					end else begin
						state_q <= ST_PH;
					end
				end
				ST_RDIV: begin
					if (div_done) begin
						state_q <= ST_RMUL;
					end
				end
				ST_RMUL: begin
					state_q <= ST_RCHK;
				end
				ST_RCHK: begin
					if (p_sh15[16:0] == 17'd0) begin
						valid_q[vidx_q] <= 1'b0;
						cnt_q           <= cnt_q - 1'b1;
						state_q         <= ST_NEXT;
					end else begin
						state_q <= ST_PH;
					end
				end
				ST_PH:   state_q <= ST_HSQ;
				ST_HSQ:  state_q <= ST_HC1;
				ST_HC1:  state_q <= ST_HC2;
				ST_HC2:  state_q <= ST_HC3;
				ST_HC3:  state_q <= ST_HC4;
				ST_HC4:  state_q <= ST_HC5;
				ST_HC5: begin
					state_q <= (h_q == 2'd3) ? ST_VT1 : ST_HSQ;
				end
				ST_VT1:  state_q <= ST_VT2;
				ST_VT2:  state_q <= ST_VT3;
				ST_VT3:  state_q <= ST_NEXT;
				ST_NEXT: begin
					if (last_v) begin
						state_q <= ST_FG;
					end else begin
						vidx_q  <= vidx_q + 1'b1;
						state_q <= ST_TRD;
					end
				end
				ST_FG:   state_q <= ST_FL0;
				ST_FL0: begin
					state_q <= (mag >= XW'(98304)) ? ST_OUT : ST_FL1;
				end
				ST_FL1:  state_q <= ST_FL2;
				ST_FL2:  state_q <= ST_FL3;
				ST_FL3: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						frame_q <= frame_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && state_q == ST_IDLE) begin
			note_q  <= s_tdata[6:0];
			vel_q   <= s_tdata[13:7];
			on_in_q <= s_tdata[45:14];
			rl_in_q <= s_tdata[77:46];
			mix_q   <= '0;
		end
		if (state_q == ST_NCMP && (vidx_q == '0 || rd_on < best_on_q)) begin
			best_q    <= vidx_q;
			best_on_q <= rd_on;
		end
		if (state_q == ST_TCHK) begin
			env_q <= 16'd32768;
		end
		if (state_q == ST_ADIV && div_done) begin
			env_q <= div_q[15:0];
		end
		if (state_q == ST_RCHK) begin
			env_q <= p_sh15[15:0];
		end
		if (state_q == ST_PH) begin
			base_q <= 32'({new_ph, {(32 - PB){1'b0}}});
			ang_q  <= 32'({new_ph, {(32 - PB){1'b0}}});
			h_q    <= 2'd0;
			acc_q  <= '0;
		end
		if (state_q == ST_HSQ) begin
			m_q <= m_comb;
		end
		if (state_q == ST_HC1) begin
			m2_q <= m2c;
		end
		if (state_q == ST_HC5) begin
			acc_q <= acc_q + 33'(prod);
			h_q   <= h_q + 1'b1;
			ang_q <= ang_q + base_q;
		end
		if (state_q == ST_VT3) begin
			mix_q <= mix_q + MIX_W'(p15s);
		end
		if (state_q == ST_FL0) begin
			neg_q <= x[XW-1];
			m_q   <= mag[16:0];
			res_q <= x[XW-1] ? -16'sd32767 : 16'sd32767;
		end
		if (state_q == ST_FL1) begin
			m2_q <= m2c;
		end
		if (state_q == ST_FL3 && div_done) begin
			res_q <= neg_q ? -{1'b0, ysat} : {1'b0, ysat};
		end
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {3'b000, 5'(cnt_q), res_q};
		end
	end

	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

endmodule

// ===== tb/polyphonic_additive_voice_synth_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the additive voice synthesizer: note, tick, seek and
// unknown command words and register writes against a cycle-free model of voices, envelopes, harmonics and limiter.
// Depends on pavs_pkg and polyphonic_additive_voice_synth.
module polyphonic_additive_voice_synth_tb;

	localparam int NV = 24;
	localparam logic [1:0] CMD_BAD = 2'd3;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct {
		logic [1:0]  cmd;
		logic [6:0]  note;
		logic [6:0]  vel;
		logic [31:0] start;
		logic [31:0] rel;
	} word_t;

	typedef struct {
		logic [15:0] smp;
		logic [4:0]  cnt;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	word_t  pending[$];
	frame_t frames_due[$];
	int     fails = 0;
	int     frames_seen = 0;
	int     hold_left = 0;
	bit     hold_done = 0;
	bit     steady = 0;

	bit          v_on[NV];
	bit [31:0]   v_phase[NV], v_step[NV], v_level[NV], v_onset[NV], v_rel[NV];
	bit [31:0]   frame_pos = 0;
	bit [15:0]   gain_r = 16'd4096, att_r = 16'd576, rls_r = 16'd4800;

	polyphonic_additive_voice_synth dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic bit [31:0] pitch_step(bit [6:0] note);
		int d, e;
		longint unsigned num, den;
		d = note + 3;
		e = d / 12 - 6 + 2;
		num = 64'd440 * pavs_pkg::SEMI_Q30[d % 12];
		if (e >= 0)
			return ((num << e) + 24000) / 48000;
		den = 64'd48000 << (-e);
		return (num + den / 2) / den;
	endfunction

	function automatic longint sine_q15(bit [31:0] a);
		longint f, m, m2, inner, mid, y;
		f = a[29:15];
		m = a[30] ? 32768 - f : f;
		m2 = (m * m) >>> 15;
		inner = 21024 - ((m2 * 2320) >>> 15);
		mid = 51472 - ((m2 * inner) >>> 15);
		y = (m * mid) >>> 15;
		return a[31] ? -y : y;
	endfunction

	function automatic longint harmonic_tone(bit [31:0] a);
		longint acc;
		bit [31:0] ah;
		acc = 0;
		for (int h = 0; h < 4; h++) begin
			ah = a * (h + 1);
			acc += longint'(pavs_pkg::HARM_W[h]) * sine_q15(ah);
		end
		return acc >>> 15;
	endfunction

	function automatic longint soft_limit(longint x);
		longint m, m2, y;
		m = x < 0 ? -x : x;
		if (m >= 98304) begin
			y = 32767;
		end else begin
			m2 = (m * m) >>> 15;
			y = (m * (884736 + m2)) / (884736 + 9 * m2);
			if (y > 32767)
				y = 32767;
		end
		return x < 0 ? -y : y;
	endfunction

	function automatic void load_voice(word_t w);
		int slot;
		bit [31:0] lvl;
		slot = -1;
		for (int i = 0; i < NV; i++)
			if (!v_on[i] && slot < 0)
				slot = i;
		if (slot < 0) begin
			slot = 0;
			for (int i = 1; i < NV; i++)
				if (v_onset[i] < v_onset[slot])
					slot = i;
		end
		lvl = (w.vel * 16384 + 63) / 127;
		if (lvl < 819)
			lvl = 819;
		v_on[slot] = 1;
		v_phase[slot] = 0;
		v_step[slot] = pitch_step(w.note);
		v_level[slot] = lvl;
		v_onset[slot] = w.start;
		v_rel[slot] = w.rel;
	endfunction

	function automatic frame_t render_frame();
		frame_t r;
		bit [31:0] age, since;
		longint env, fac, mix;
		int cnt;
		mix = 0;
		cnt = 0;
		for (int i = 0; i < NV; i++) begin
			if (!v_on[i] || frame_pos < v_onset[i])
				continue;
			age = frame_pos - v_onset[i];
			env = 32768;
			if (age < att_r)
				env = (longint'(age) * 32768) / longint'(att_r);
			if (frame_pos >= v_rel[i]) begin
				since = frame_pos - v_rel[i];
				fac = 0;
				if (since < rls_r)
					fac = (longint'(rls_r - since) * 32768) / longint'(rls_r);
				env = (env * fac) >>> 15;
				if (env <= 0) begin
					v_on[i] = 0;
					continue;
				end
			end
			v_phase[i] = v_phase[i] + v_step[i];
			mix += (((harmonic_tone(v_phase[i]) * longint'(v_level[i])) >>> 15) * env) >>> 15;
		end
		for (int i = 0; i < NV; i++)
			if (v_on[i])
				cnt++;
		frame_pos = frame_pos + 1;
		r.smp = soft_limit((mix * longint'(gain_r)) >>> 12);
		r.cnt = cnt;
		return r;
	endfunction

	function automatic void apply_word(word_t w);
		case (w.cmd)
			pavs_pkg::CMD_NOTE: load_voice(w);
			pavs_pkg::CMD_SEEK: begin
				for (int i = 0; i < NV; i++)
					v_on[i] = 0;
				frame_pos = w.start;
			end
			pavs_pkg::CMD_TICK: frames_due.push_back(render_frame());
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				w.cmd = s_tuser;
				{w.rel, w.start, w.vel, w.note} = s_tdata[77:0];
				apply_word(w);
			end
			if (!s_tvalid || s_tready) begin
				if (pending.size() > 0 && (steady || $urandom_range(99) >= 37)) begin
					w = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= w.cmd;
					s_tdata <= {2'b00, w.rel, w.start, w.vel, w.note};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		frame_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				frames_seen++;
				if (frames_due.size() == 0) begin
					$error("unexpected word: sample_out %0d voices_active %0d",
						$signed(m_tdata[15:0]), m_tdata[20:16]);
					fails++;
				end else begin
					e = frames_due.pop_front();
					if (m_tdata[15:0] !== e.smp) begin
						$error("sample_out expected %0d actual %0d",
							$signed(e.smp), $signed(m_tdata[15:0]));
						fails++;
					end
					if (m_tdata[20:16] !== e.cnt) begin
						$error("voices_active expected %0d actual %0d",
							e.cnt, m_tdata[20:16]);
						fails++;
					end
				end
			end
			if (!hold_done && frames_seen >= 150) begin
				hold_done <= 1;
				hold_left <= 4000;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || $urandom_range(99) >= 37;
			end
		end
	end

	task automatic push_word(logic [1:0] c, logic [6:0] n, logic [6:0] v,
			logic [31:0] st, logic [31:0] rl);
		word_t w;
		w.cmd = c;
		w.note = n;
		w.vel = v;
		w.start = st;
		w.rel = rl;
		pending.push_back(w);
	endtask

	task automatic drain();
		while (pending.size() > 0 || s_tvalid || frames_due.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			pavs_pkg::REG_GAIN:    gain_r = val;
			pavs_pkg::REG_ATTACK:  att_r = val;
			pavs_pkg::REG_RELEASE: rls_r = val;
			default: ;
		endcase
	endtask

	task automatic fill_run(int n);
		bit [31:0] pos, st;
		int k, r, burst;
		pos = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - $urandom_range(60) : $urandom;
		push_word(pavs_pkg::CMD_SEEK, $urandom, $urandom, pos, $urandom);
		k = 0;
		while (k < n) begin
			r = $urandom_range(99);
			if (r < 45) begin
				push_word(pavs_pkg::CMD_TICK, $urandom, $urandom, $urandom, $urandom);
				pos++;
			end else if (r < 75) begin
				st = pos + $urandom_range(20);
				push_word(pavs_pkg::CMD_NOTE, $urandom, $urandom, st,
					st + $urandom_range(100));
			end else if (r < 80) begin
				burst = $urandom_range(28, 20);
				repeat (burst) begin
					st = pos + $urandom_range(20);
					push_word(pavs_pkg::CMD_NOTE, $urandom, $urandom, st,
						st + $urandom_range(100));
				end
				k += burst - 1;
			end else if (r < 85) begin
				pos = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF - $urandom_range(40) : $urandom;
				push_word(pavs_pkg::CMD_SEEK, $urandom, $urandom, pos, $urandom);
			end else if (r < 88) begin
				push_word(CMD_BAD, $urandom, $urandom, $urandom, $urandom);
			end else begin
				push_word(pavs_pkg::CMD_NOTE, $urandom, $urandom, $urandom, $urandom);
			end
			k++;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_word(pavs_pkg::CMD_TICK, 7'd0, 7'd0, 32'd0, 32'd0);
		push_word(pavs_pkg::CMD_NOTE, 7'd0, 7'd0, 32'd0, 32'd0);
		push_word(pavs_pkg::CMD_NOTE, 7'd127, 7'd127, 32'd0, 32'hFFFF_FFFF);
		push_word(pavs_pkg::CMD_NOTE, 7'd69, 7'd64, 32'd3, 32'd6);
		push_word(CMD_BAD, 7'h7F, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		repeat (6) push_word(pavs_pkg::CMD_TICK, 7'd0, 7'd0, 32'd0, 32'd0);
		push_word(pavs_pkg::CMD_SEEK, 7'h7F, 7'h7F, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		push_word(pavs_pkg::CMD_NOTE, 7'd60, 7'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_word(pavs_pkg::CMD_NOTE, 7'd45, 7'd100, 32'hFFFF_FFFE, 32'd0);
		repeat (4) push_word(pavs_pkg::CMD_TICK, 7'd0, 7'd0, 32'd0, 32'd0);
		push_word(pavs_pkg::CMD_SEEK, 7'd0, 7'd0, 32'd0, 32'd0);
		push_word(pavs_pkg::CMD_TICK, 7'd0, 7'd0, 32'd0, 32'd0);
		drain();

		write_reg(pavs_pkg::REG_GAIN, 16'hFFFF);
		write_reg(pavs_pkg::REG_ATTACK, 16'd1);
		write_reg(pavs_pkg::REG_RELEASE, 16'd1);
		fill_run(300);
		drain();

		write_reg(pavs_pkg::REG_GAIN, 16'd0);
		write_reg(pavs_pkg::REG_ATTACK, 16'hFFFF);
		write_reg(pavs_pkg::REG_RELEASE, 16'hFFFF);
		write_reg(REG_NONE, 16'h1234);
		fill_run(150);
		drain();

		for (int p = 0; p < 4; p++) begin
			write_reg(pavs_pkg::REG_GAIN, $urandom_range(20000, 1000));
			write_reg(pavs_pkg::REG_ATTACK, $urandom_range(40, 1));
			write_reg(pavs_pkg::REG_RELEASE, $urandom_range(120, 1));
			steady = (p == 2);
			fill_run(300);
			drain();
		end
		steady = 0;

		repeat (200) @(posedge clk);
		if (frames_due.size() != 0)
			fails++;
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#100ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
